>>> rtl/psf_pkg.sv
// -----------------------------------------------------------------------------
// psf_pkg
// Shared widths, register indexes, reset values and the control structs of
// the packed pixel span fill core.
// -----------------------------------------------------------------------------
package psf_pkg;

   localparam int PIXELS_PER_WORD    = 8;
   localparam int NIB_W              = 3;    // log2 of pixels per word
   localparam int MAX_ROW_PIXELS_DEF = 256;

   localparam int COORD_W   = 12;
   localparam int PAT_W     = 32;
   localparam int ADDR_W    = 20;
   localparam int EN_W      = 8;
   localparam int ROWPIX_W  = 9;
   localparam int CLIPX_W   = 8;
   localparam int CLIPY_W   = 10;
   localparam int PROD_W    = COORD_W + ROWPIX_W + 1;
   localparam int OFF_W     = PROD_W + 1;
   localparam int WORD_W    = OFF_W - NIB_W;
   // a 12-bit column range spans at most 513 words, so the word gap fits 10 bits
   localparam int DIFF_W    = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_PIXELS  = 3'd0,
      CSR_BASE_WORD   = 3'd1,
      CSR_CLIP_ENABLE = 3'd2,
      CSR_CLIP_LEFT   = 3'd3,
      CSR_CLIP_RIGHT  = 3'd4,
      CSR_CLIP_TOP    = 3'd5,
      CSR_CLIP_BOTTOM = 3'd6
   } csr_index_type;

   localparam logic [ROWPIX_W-1:0] ROW_PIXELS_RST  = 9'd256;
   localparam logic [ADDR_W-1:0]   BASE_WORD_RST   = '0;
   localparam logic                CLIP_ENABLE_RST = 1'b1;
   localparam logic [CLIPX_W-1:0]  CLIP_LEFT_RST   = 8'd0;
   localparam logic [CLIPX_W-1:0]  CLIP_RIGHT_RST  = 8'd255;
   localparam logic [CLIPY_W-1:0]  CLIP_TOP_RST    = 10'd0;
   localparam logic [CLIPY_W-1:0]  CLIP_BOTTOM_RST = 10'd1023;

   typedef struct packed {
      logic [ROWPIX_W-1:0] row_pixels;
      logic [ADDR_W-1:0]   base_word;
      logic                clip_enable;
      logic [CLIPX_W-1:0]  clip_left;
      logic [CLIPX_W-1:0]  clip_right;
      logic [CLIPY_W-1:0]  clip_top;
      logic [CLIPY_W-1:0]  clip_bottom;
   } cfg_type;

   typedef struct packed {
      logic load;     // capture request
      logic clip;     // clip test and clamp
      logic mul;      // row times stride
      logic setup;    // word indexes, masks, count
      logic advance;  // result word taken
   } cmd_type;

   typedef struct packed {
      logic drop;     // span is empty or off the rectangle
      logic last;     // current word closes the span
   } status_type;

endpackage

>>> rtl/psf_regs.sv
// -----------------------------------------------------------------------------
// psf_regs
// Configuration register file: index decode, write and reset values.
// -----------------------------------------------------------------------------
module psf_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [psf_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [psf_pkg::CSR_DATA_W-1:0]   wr_data,
   output psf_pkg::cfg_type                 cfg
);

   psf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            psf_pkg::CSR_ROW_PIXELS:
               cfg_in.row_pixels  = wr_data[psf_pkg::ROWPIX_W-1:0];
            psf_pkg::CSR_BASE_WORD:
               cfg_in.base_word   = wr_data[psf_pkg::ADDR_W-1:0];
            psf_pkg::CSR_CLIP_ENABLE:
               cfg_in.clip_enable = wr_data[0];
            psf_pkg::CSR_CLIP_LEFT:
               cfg_in.clip_left   = wr_data[psf_pkg::CLIPX_W-1:0];
            psf_pkg::CSR_CLIP_RIGHT:
               cfg_in.clip_right  = wr_data[psf_pkg::CLIPX_W-1:0];
            psf_pkg::CSR_CLIP_TOP:
               cfg_in.clip_top    = wr_data[psf_pkg::CLIPY_W-1:0];
            psf_pkg::CSR_CLIP_BOTTOM:
               cfg_in.clip_bottom = wr_data[psf_pkg::CLIPY_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_pixels  <= psf_pkg::ROW_PIXELS_RST;
         cfg_ff.base_word   <= psf_pkg::BASE_WORD_RST;
         cfg_ff.clip_enable <= psf_pkg::CLIP_ENABLE_RST;
         cfg_ff.clip_left   <= psf_pkg::CLIP_LEFT_RST;
         cfg_ff.clip_right  <= psf_pkg::CLIP_RIGHT_RST;
         cfg_ff.clip_top    <= psf_pkg::CLIP_TOP_RST;
         cfg_ff.clip_bottom <= psf_pkg::CLIP_BOTTOM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/psf_ctrl.sv
// -----------------------------------------------------------------------------
// psf_ctrl
// Sequencer: capture, clip, multiply, set up, then one word per transaction; a dropped span returns to idle.
// -----------------------------------------------------------------------------
module psf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  psf_pkg::status_type status,
   output psf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_MUL,
      ST_SETUP,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.load    = req_ready_ff && req_valid;
      cmd.clip    = (state_ff == ST_CLIP);
      cmd.mul     = (state_ff == ST_MUL) && !status.drop;
      cmd.setup   = (state_ff == ST_SETUP);
      cmd.advance = rsp_valid_ff && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_CLIP;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_CLIP: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (status.drop) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end else begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff     <= ST_EMIT;
               rsp_valid_ff <= 1'b1;
            end
            ST_EMIT: begin
               if (rsp_ready && status.last) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/psf_dpath.sv
// -----------------------------------------------------------------------------
// psf_dpath
// Span datapath: clip and clamp, row offset multiply, word and nibble split,
// edge masks, and the word address / remaining count for emission.
// -----------------------------------------------------------------------------
module psf_dpath #(
   parameter int MAX_ROW_PIXELS = psf_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                                clock,
   input  psf_pkg::cfg_type                    cfg,
   input  psf_pkg::cmd_type                    cmd,
   output psf_pkg::status_type                 status,
   input  logic signed [psf_pkg::COORD_W-1:0]  row_y,
   input  logic signed [psf_pkg::COORD_W-1:0]  x_start,
   input  logic signed [psf_pkg::COORD_W-1:0]  x_end,
   input  logic [psf_pkg::PAT_W-1:0]           fill_pattern,
   output logic [psf_pkg::ADDR_W-1:0]          word_addr,
   output logic [psf_pkg::PAT_W-1:0]           write_data,
   output logic [psf_pkg::EN_W-1:0]            nibble_enable,
   output logic                                last_write
);

   localparam int MAX_WORDS = MAX_ROW_PIXELS / psf_pkg::PIXELS_PER_WORD + 1;
   localparam int REM_W     = $clog2(MAX_WORDS);
   localparam int CW        = psf_pkg::COORD_W;

   logic signed [CW-1:0]             y_ff, xl_ff, xr_ff;
   logic signed [CW-1:0]             xl_in, xr_in;
   logic [psf_pkg::PAT_W-1:0]        pat_ff;
   logic                             drop_ff, drop_in;
   logic signed [psf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [psf_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [REM_W-1:0]                 rem_ff, rem_in;
   logic                             first_ff, first_in;
   logic                             cut_ff, cut_in;
   logic [psf_pkg::EN_W-1:0]         ml_ff, ml_in, mr_ff, mr_in;

   // clip test, all compares one bit wider so the unsigned limits stay positive
   logic signed [CW:0] y_x, xl_x, xr_x, top_x, bot_x, left_x, right_x;
   logic signed [psf_pkg::OFF_W-1:0]  loff, roff;
   logic signed [psf_pkg::WORD_W-1:0] lw, rw;
   logic [psf_pkg::WORD_W-1:0]        diff;
   logic [psf_pkg::NIB_W-1:0]         lnib, rnib;

   always_comb begin
      y_x     = {y_ff[CW-1], y_ff};
      xl_x    = {xl_ff[CW-1], xl_ff};
      xr_x    = {xr_ff[CW-1], xr_ff};
      top_x   = $signed({{(CW+1-psf_pkg::CLIPY_W){1'b0}}, cfg.clip_top});
      bot_x   = $signed({{(CW+1-psf_pkg::CLIPY_W){1'b0}}, cfg.clip_bottom});
      left_x  = $signed({{(CW+1-psf_pkg::CLIPX_W){1'b0}}, cfg.clip_left});
      right_x = $signed({{(CW+1-psf_pkg::CLIPX_W){1'b0}}, cfg.clip_right});

      xl_in   = xl_ff;
      xr_in   = xr_ff;
      drop_in = 1'b0;
      if (cfg.clip_enable) begin
         if (y_x < top_x || y_x > bot_x || xr_x < left_x || xl_x > right_x) begin
            drop_in = 1'b1;
         end
         if (xl_x < left_x) begin
            xl_in = left_x[CW-1:0];
         end
         if (xr_x > right_x) begin
            xr_in = right_x[CW-1:0];
         end
      end
      if (xl_in > xr_in) begin
         drop_in = 1'b1;
      end
   end

   // operands widened first so the product keeps all its bits
   assign prod_in = psf_pkg::PROD_W'(y_ff) *
                    psf_pkg::PROD_W'($signed({1'b0, cfg.row_pixels}));

   always_comb begin
      loff = psf_pkg::OFF_W'(prod_ff) + psf_pkg::OFF_W'(xl_ff);
      roff = psf_pkg::OFF_W'(prod_ff) + psf_pkg::OFF_W'(xr_ff);
      // arithmetic shift gives the floored word index
      lw   = loff[psf_pkg::OFF_W-1:psf_pkg::NIB_W];
      rw   = roff[psf_pkg::OFF_W-1:psf_pkg::NIB_W];
      lnib = loff[psf_pkg::NIB_W-1:0];
      rnib = roff[psf_pkg::NIB_W-1:0];
      diff = rw - lw;
      ml_in = psf_pkg::EN_W'({psf_pkg::EN_W{1'b1}} << lnib);
      mr_in = psf_pkg::EN_W'({psf_pkg::EN_W{1'b1}} >> (3'd7 - rnib));
      cut_in = (diff[psf_pkg::DIFF_W-1:0] >= psf_pkg::DIFF_W'(MAX_WORDS));
   end

   always_comb begin
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      first_in = first_ff;
      if (cmd.setup) begin
         addr_in  = cfg.base_word + lw[psf_pkg::ADDR_W-1:0];
         rem_in   = cut_in ? REM_W'(MAX_WORDS - 1) : diff[REM_W-1:0];
         first_in = 1'b1;
      end else if (cmd.advance) begin
         addr_in  = addr_ff + psf_pkg::ADDR_W'(1);
         rem_in   = rem_ff - REM_W'(1);
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         y_ff   <= row_y;
         xl_ff  <= x_start;
         xr_ff  <= x_end;
         pat_ff <= fill_pattern;
      end else if (cmd.clip) begin
         xl_ff   <= xl_in;
         xr_ff   <= xr_in;
      end
      if (cmd.clip) begin
         drop_ff <= drop_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.setup) begin
         ml_ff  <= ml_in;
         mr_ff  <= mr_in;
         cut_ff <= cut_in;
      end
      addr_ff  <= addr_in;
      rem_ff   <= rem_in;
      first_ff <= first_in;
   end

   always_comb begin
      status.drop = drop_ff;
      status.last = (rem_ff == '0);
      nibble_enable = {psf_pkg::EN_W{1'b1}};
      if (first_ff) begin
         nibble_enable = nibble_enable & ml_ff;
      end
      if (status.last && !cut_ff) begin
         nibble_enable = nibble_enable & mr_ff;
      end
   end

   assign word_addr  = addr_ff;
   assign write_data = pat_ff;
   assign last_write = status.last;

endmodule

>>> rtl/packed_pixel_span_fill_core.sv
// A request is captured, then passes the clip, multiply and setup states before its first word write.
// Throughput: spans of N words (N up to MAX_ROW_PIXELS/8 + 1), paced by the sequencer,
// which holds one span at a time and emits one word a cycle while rsp_ready is high.
// A dropped or empty span writes no word and frees the request channel from the multiply state.
// Reset: synchronous, active high; sequencer idles and the configuration registers take their reset values.
// -----------------------------------------------------------------------------
// packed_pixel_span_fill_core
// Horizontal span fill for a 4 bpp packed frame buffer with rectangle clipping.
// -----------------------------------------------------------------------------
module packed_pixel_span_fill_core #(
   parameter int MAX_ROW_PIXELS = psf_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [psf_pkg::COORD_W-1:0] req_row_y,
   input  logic signed [psf_pkg::COORD_W-1:0] req_x_start,
   input  logic signed [psf_pkg::COORD_W-1:0] req_x_end,
   input  logic [psf_pkg::PAT_W-1:0]          req_fill_pattern,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psf_pkg::ADDR_W-1:0]         rsp_word_addr,
   output logic [psf_pkg::PAT_W-1:0]          rsp_write_data,
   output logic [psf_pkg::EN_W-1:0]           rsp_nibble_enable,
   output logic                               rsp_last_write,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [psf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psf_pkg::CSR_DATA_W-1:0]     csr_data
);

   psf_pkg::cfg_type    cfg;
   psf_pkg::cmd_type    cmd;
   psf_pkg::status_type status;

   assign csr_ready = 1'b1;

   psf_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   psf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psf_dpath #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_dpath (
      .clock         (clock),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .row_y         (req_row_y),
      .x_start       (req_x_start),
      .x_end         (req_x_end),
      .fill_pattern  (req_fill_pattern),
      .word_addr     (rsp_word_addr),
      .write_data    (rsp_write_data),
      .nibble_enable (rsp_nibble_enable),
      .last_write    (rsp_last_write)
   );

endmodule

>>> dv/span_fill_sb_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// span_fill_sb_pkg
// Scoreboard for the span fill core. It models the register file, works out
// the masked word writes of each accepted span and checks the write stream.
// -----------------------------------------------------------------------------
package span_fill_sb_pkg;

   import psf_pkg::*;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [PAT_W-1:0]  data;
      logic [EN_W-1:0]   en;
      logic              last;
   } frame_write_type;

   class span_fill_scoreboard;
      cfg_type         regs;
      frame_write_type pending_writes[$];
      int unsigned     err_count;
      longint          max_words;

      function new(int unsigned words_cap);
         max_words = words_cap;
         err_count = 0;
         regs.row_pixels  = ROW_PIXELS_RST;
         regs.base_word   = BASE_WORD_RST;
         regs.clip_enable = CLIP_ENABLE_RST;
         regs.clip_left   = CLIP_LEFT_RST;
         regs.clip_right  = CLIP_RIGHT_RST;
         regs.clip_top    = CLIP_TOP_RST;
         regs.clip_bottom = CLIP_BOTTOM_RST;
      endfunction

      function int unsigned pending();
         return pending_writes.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ROW_PIXELS:  regs.row_pixels  = data[ROWPIX_W-1:0];
            CSR_BASE_WORD:   regs.base_word   = data[ADDR_W-1:0];
            CSR_CLIP_ENABLE: regs.clip_enable = data[0];
            CSR_CLIP_LEFT:   regs.clip_left   = data[CLIPX_W-1:0];
            CSR_CLIP_RIGHT:  regs.clip_right  = data[CLIPX_W-1:0];
            CSR_CLIP_TOP:    regs.clip_top    = data[CLIPY_W-1:0];
            CSR_CLIP_BOTTOM: regs.clip_bottom = data[CLIPY_W-1:0];
            default: ;
         endcase
      endfunction

      // works out the word writes of one span transaction
      function void note_span(logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] xs,
                              logic signed [COORD_W-1:0] xe, logic [PAT_W-1:0] pat);
         longint          row, xl, xr, loff, roff, lw, rw, nwords, k, addr_sum;
         int              lnib, rnib;
         logic [EN_W-1:0] ml, mr, en;
         bit              cut;
         frame_write_type w;
         row = y;
         xl  = xs;
         xr  = xe;
         if (regs.clip_enable) begin
            if (row < longint'(regs.clip_top) || row > longint'(regs.clip_bottom))
               return;
            if (xr < longint'(regs.clip_left) || xl > longint'(regs.clip_right))
               return;
            if (xl < longint'(regs.clip_left))
               xl = regs.clip_left;
            if (xr > longint'(regs.clip_right))
               xr = regs.clip_right;
         end
         if (xl > xr)
            return;
         loff = row * longint'(regs.row_pixels) + xl;
         roff = row * longint'(regs.row_pixels) + xr;
         // arithmetic shift floors negative offsets
         lw   = loff >>> NIB_W;
         rw   = roff >>> NIB_W;
         lnib = int'(loff & (PIXELS_PER_WORD - 1));
         rnib = int'(roff & (PIXELS_PER_WORD - 1));
         ml   = 8'hFF << lnib;
         mr   = 8'hFF >> (7 - rnib);
         nwords = rw - lw + 1;
         cut    = 1'b0;
         if (nwords > max_words) begin
            nwords = max_words;
            cut    = 1'b1;
         end
         for (k = 0; k < nwords; k++) begin
            en = 8'hFF;
            if (k == 0)
               en &= ml;
            // a cut span closes on a full word
            if (k == nwords - 1 && !cut)
               en &= mr;
            addr_sum = longint'(regs.base_word) + lw + k;
            w.addr = addr_sum[ADDR_W-1:0];
            w.data = pat;
            w.en   = en;
            w.last = (k == nwords - 1);
            pending_writes.push_back(w);
         end
      endfunction

      function void check_write(logic [ADDR_W-1:0] addr, logic [PAT_W-1:0] data,
                                logic [EN_W-1:0] en, logic last);
         frame_write_type w;
         if (pending_writes.size() == 0) begin
            $error("unexpected word write: addr %h data %h en %h last %b",
                   addr, data, en, last);
            err_count++;
            return;
         end
         w = pending_writes.pop_front();
         if (addr !== w.addr) begin
            $error("word_addr: expected %h, got %h", w.addr, addr);
            err_count++;
         end
         if (data !== w.data) begin
            $error("write_data: expected %h, got %h", w.data, data);
            err_count++;
         end
         if (en !== w.en) begin
            $error("nibble_enable: expected %h, got %h", w.en, en);
            err_count++;
         end
         if (last !== w.last) begin
            $error("last_write: expected %b, got %b", w.last, last);
            err_count++;
         end
      endfunction
   endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Drives span requests and register writes into the span fill core under
// random idling and back-pressure, and checks every masked word write against
// the scoreboard's own prediction.
// -----------------------------------------------------------------------------
module tb_top;

   import psf_pkg::*;
   import span_fill_sb_pkg::*;

   localparam int MAX_ROW_PIXELS  = MAX_ROW_PIXELS_DEF;
   localparam int MAX_WORDS       = MAX_ROW_PIXELS / PIXELS_PER_WORD + 1;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_LIMIT     = 100000;
   localparam int SPANS_PER_PHASE = 28;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [COORD_W-1:0]  req_row_y;
   logic signed [COORD_W-1:0]  req_x_start;
   logic signed [COORD_W-1:0]  req_x_end;
   logic [PAT_W-1:0]           req_fill_pattern;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [ADDR_W-1:0]          rsp_word_addr;
   logic [PAT_W-1:0]           rsp_write_data;
   logic [EN_W-1:0]            rsp_nibble_enable;
   logic                       rsp_last_write;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   span_fill_scoreboard sb = new(MAX_WORDS);
   cfg_type             cur_cfg;
   bit                  no_idle = 1'b0;
   bit                  hold_off_req = 1'b0;

   packed_pixel_span_fill_core #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row_y         (req_row_y),
      .req_x_start       (req_x_start),
      .req_x_end         (req_x_end),
      .req_fill_pattern  (req_fill_pattern),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_addr     (rsp_word_addr),
      .rsp_write_data    (rsp_write_data),
      .rsp_nibble_enable (rsp_nibble_enable),
      .rsp_last_write    (rsp_last_write),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r < 8)
         return 0;
      if (r < 14)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic cfg_type make_cfg(int rp, int base, int en, int cl, int cr,
                                        int ct, int cb);
      cfg_type c;
      c.row_pixels  = rp[ROWPIX_W-1:0];
      c.base_word   = base[ADDR_W-1:0];
      c.clip_enable = en[0];
      c.clip_left   = cl[CLIPX_W-1:0];
      c.clip_right  = cr[CLIPX_W-1:0];
      c.clip_top    = ct[CLIPY_W-1:0];
      c.clip_bottom = cb[CLIPY_W-1:0];
      return c;
   endfunction

   task automatic send_span(logic [COORD_W-1:0] y, logic [COORD_W-1:0] xs,
                            logic [COORD_W-1:0] xe, logic [PAT_W-1:0] pat);
      int unsigned gap;
      gap = no_idle ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_row_y        <= y;
      req_x_start      <= xs;
      req_x_end        <= xe;
      req_fill_pattern <= pat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // dropped spans leave no trace in the queue, hence the settle cycles
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // unused upper data bits are filled with noise
   task automatic set_config(cfg_type c);
      logic [CSR_DATA_W-1:0] d;
      d = $urandom; d[ROWPIX_W-1:0] = c.row_pixels;  write_csr(CSR_ROW_PIXELS, d);
      d = $urandom; d[ADDR_W-1:0]   = c.base_word;   write_csr(CSR_BASE_WORD, d);
      d = $urandom; d[0]            = c.clip_enable; write_csr(CSR_CLIP_ENABLE, d);
      d = $urandom; d[CLIPX_W-1:0]  = c.clip_left;   write_csr(CSR_CLIP_LEFT, d);
      d = $urandom; d[CLIPX_W-1:0]  = c.clip_right;  write_csr(CSR_CLIP_RIGHT, d);
      d = $urandom; d[CLIPY_W-1:0]  = c.clip_top;    write_csr(CSR_CLIP_TOP, d);
      d = $urandom; d[CLIPY_W-1:0]  = c.clip_bottom; write_csr(CSR_CLIP_BOTTOM, d);
      cur_cfg = c;
   endtask

   // mostly spans near the visible window, the rest raw noise
   task automatic random_span();
      int lo_x, hi_x, lo_y, hi_y, xs, xe, yy;
      if (cur_cfg.clip_enable) begin
         lo_x = (cur_cfg.clip_left < cur_cfg.clip_right) ? cur_cfg.clip_left : cur_cfg.clip_right;
         hi_x = (cur_cfg.clip_left < cur_cfg.clip_right) ? cur_cfg.clip_right : cur_cfg.clip_left;
         lo_y = (cur_cfg.clip_top < cur_cfg.clip_bottom) ? cur_cfg.clip_top : cur_cfg.clip_bottom;
         hi_y = (cur_cfg.clip_top < cur_cfg.clip_bottom) ? cur_cfg.clip_bottom : cur_cfg.clip_top;
         lo_x = lo_x - 8;
         hi_x = hi_x + 8;
         lo_y = lo_y - 2;
         hi_y = hi_y + 2;
      end else begin
         lo_x = -16;
         hi_x = int'(cur_cfg.row_pixels) + 16;
         lo_y = 0;
         hi_y = 63;
      end
      if ($urandom_range(0, 3) == 0) begin
         send_span(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), $urandom);
      end else begin
         yy = lo_y + int'($urandom_range(0, hi_y - lo_y));
         xs = lo_x + int'($urandom_range(0, hi_x - lo_x));
         if ($urandom_range(0, 9) == 0)
            xe = xs - int'($urandom_range(1, 8));
         else if ($urandom_range(0, 7) == 0)
            xe = xs + int'($urandom_range(0, 320));
         else
            xe = xs + int'($urandom_range(0, 24));
         send_span(yy[COORD_W-1:0], xs[COORD_W-1:0], xe[COORD_W-1:0], $urandom);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.note_span(req_row_y, req_x_start, req_x_end, req_fill_pattern);
         if (rsp_valid && rsp_ready)
            sb.check_write(rsp_word_addr, rsp_write_data, rsp_nibble_enable, rsp_last_write);
      end
   end

   initial begin : rsp_side
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
            repeat (1 + idle_len()) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int i;
      int ph;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_row_y        <= '0;
      req_x_start      <= '0;
      req_x_end        <= '0;
      req_fill_pattern <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_ROW_PIXELS;
      csr_data         <= '0;
      cur_cfg = make_cfg(ROW_PIXELS_RST, BASE_WORD_RST, CLIP_ENABLE_RST, CLIP_LEFT_RST,
                         CLIP_RIGHT_RST, CLIP_TOP_RST, CLIP_BOTTOM_RST);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: clamping, edges, empty and off-window spans
      send_span(12'sd0, 12'sd0, 12'sd255, 32'h0123_4567);
      send_span(12'sd5, -12'sd2048, 12'sd2047, 32'hFFFF_FFFF);
      send_span(12'sd1, 12'sd3, 12'sd3, 32'h0000_0000);
      send_span(12'sd2, 12'sd9, 12'sd14, $urandom);
      send_span(12'sd3, 12'sd7, 12'sd8, $urandom);
      send_span(12'sd4, 12'sd10, 12'sd5, $urandom);
      send_span(-12'sd1, 12'sd0, 12'sd10, $urandom);
      send_span(12'sd1023, 12'sd250, 12'sd260, $urandom);
      send_span(12'sd1024, 12'sd0, 12'sd10, $urandom);
      send_span(12'sd2047, 12'sd0, 12'sd10, $urandom);
      send_span(12'sd6, -12'sd100, -12'sd1, $urandom);
      send_span(12'sd6, 12'sd256, 12'sd300, $urandom);

      // no clipping: negative offsets, address wrap, word cap
      wait_idle();
      set_config(make_cfg(256, 'hFFFFF, 0, 0, 255, 0, 1023));
      send_span(-12'sd2048, -12'sd2048, 12'sd2047, $urandom);
      send_span(12'sd2047, 12'sd2040, 12'sd2047, $urandom);
      send_span(-12'sd1, -12'sd5, 12'sd3, $urandom);
      send_span(12'sd0, 12'sd4, 12'sd263, $urandom);
      send_span(12'sd0, 12'sd4, 12'sd271, $urandom);
      send_span(12'sd0, 12'sd9, 12'sd5, $urandom);

      // inverted column window, widest stride
      wait_idle();
      set_config(make_cfg(511, 'h12345, 1, 200, 50, 100, 900));
      send_span(12'sd300, 12'sd10, 12'sd250, $urandom);
      send_span(12'sd300, 12'sd100, 12'sd150, $urandom);

      // zero stride, one-pixel window at the far corner
      wait_idle();
      write_csr(CSR_SPARE_IDX, $urandom);
      set_config(make_cfg(0, 7, 1, 255, 255, 1023, 1023));
      send_span(12'sd1023, 12'sd0, 12'sd2047, $urandom);
      send_span(12'sd1022, 12'sd0, 12'sd2047, $urandom);

      for (ph = 0; ph < 5; ph++) begin
         wait_idle();
         case (ph)
            0: set_config(make_cfg(256, $urandom, 1, $urandom_range(0, 60),
                                   $urandom_range(100, 255), $urandom_range(0, 200),
                                   $urandom_range(300, 1023)));
            1: set_config(make_cfg($urandom_range(1, 64), $urandom, 0, $urandom,
                                   $urandom, $urandom, $urandom));
            2: set_config(make_cfg(1, 'hFFFFF, 1, 0, 255, 0, 1023));
            3: set_config(make_cfg($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom));
            default: set_config(make_cfg(256, 0, 1, 0, 255, 0, 1023));
         endcase
         no_idle = (ph == 2);
         for (i = 0; i < SPANS_PER_PHASE; i++) begin
            // output stalls for a long stretch while requests keep coming
            if (ph == 4 && i == 4)
               hold_off_req = 1'b1;
            random_span();
         end
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      for (i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d word writes never arrived", sb.pending());
         sb.err_count++;
      end
      if (sb.err_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin : watchdog
      #15_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/psf_pkg.sv
rtl/psf_regs.sv
rtl/psf_ctrl.sv
rtl/psf_dpath.sv
rtl/packed_pixel_span_fill_core.sv
dv/span_fill_sb_pkg.sv
dv/tb_top.sv
